### rtl/core/rfpa_pkg.sv
// Package for the register-to-register fixed-point unit.
// Holds instruction and exception codes, widths and the shared-unit handshake types.
// No dependencies.
package rfpa_pkg;

  localparam int NUM_REGISTERS = 16;
  localparam int REG_AW = $clog2(NUM_REGISTERS);
  localparam int WORD_W = 32;

  // Instruction selectors, low nibble of the opcode.
  localparam logic [3:0] OP_LPR = 4'd0;
  localparam logic [3:0] OP_LNR = 4'd1;
  localparam logic [3:0] OP_LTR = 4'd2;
  localparam logic [3:0] OP_LCR = 4'd3;
  localparam logic [3:0] OP_NR  = 4'd4;
  localparam logic [3:0] OP_CLR = 4'd5;
  localparam logic [3:0] OP_OR  = 4'd6;
  localparam logic [3:0] OP_XR  = 4'd7;
  localparam logic [3:0] OP_LR  = 4'd8;
  localparam logic [3:0] OP_CR  = 4'd9;
  localparam logic [3:0] OP_AR  = 4'd10;
  localparam logic [3:0] OP_SR  = 4'd11;
  localparam logic [3:0] OP_MR  = 4'd12;
  localparam logic [3:0] OP_DR  = 4'd13;
  localparam logic [3:0] OP_ALR = 4'd14;
  localparam logic [3:0] OP_SLR = 4'd15;

  // Input kinds.
  localparam logic KIND_EXEC  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // Exception codes.
  localparam logic [1:0] EXC_NONE = 2'd0;
  localparam logic [1:0] EXC_SPEC = 2'd1;
  localparam logic [1:0] EXC_OVF  = 2'd2;
  localparam logic [1:0] EXC_DIV  = 2'd3;

  // Condition codes.
  localparam logic [1:0] CC_ZERO = 2'd0;
  localparam logic [1:0] CC_LOW  = 2'd1;
  localparam logic [1:0] CC_HIGH = 2'd2;
  localparam logic [1:0] CC_OVF  = 2'd3;

  localparam logic [WORD_W-1:0] SIGN32 = 32'h8000_0000;

  // Request to the shared multiply/divide unit.
  typedef struct packed {
    logic start;
    logic is_div;
  } iter_req_t;

  // Result of the shared multiply/divide unit; hi and lo hold after done.
  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] hi;
    logic [WORD_W-1:0] lo;
  } iter_res_t;

endpackage

### rtl/core/rfpa_regfile.sv
// General register file: one write port, two registered read ports.
// Per-entry valid bits make unwritten registers read as zero after reset.
// Depends on rfpa_pkg.
module rfpa_regfile (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         we,
  input  logic [rfpa_pkg::REG_AW-1:0]  waddr,
  input  logic [rfpa_pkg::WORD_W-1:0]  wdata,
  input  logic [rfpa_pkg::REG_AW-1:0]  raddr_a,
  input  logic [rfpa_pkg::REG_AW-1:0]  raddr_b,
  output logic [rfpa_pkg::WORD_W-1:0]  rdata_a,
  output logic [rfpa_pkg::WORD_W-1:0]  rdata_b
);
  import rfpa_pkg::*;

  logic [WORD_W-1:0]        mem [NUM_REGISTERS];
  logic [NUM_REGISTERS-1:0] valid;
  logic [WORD_W-1:0]        q_a;
  logic [WORD_W-1:0]        q_b;
  logic                     v_a;
  logic                     v_b;

  // Storage array and registered reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    q_a <= mem[raddr_a];
    q_b <= mem[raddr_b];
  end

  // Valid bits, cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      v_a   <= 1'b0;
      v_b   <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      v_a <= valid[raddr_a];
      v_b <= valid[raddr_b];
    end
  end

  assign rdata_a = v_a ? q_a : '0;
  assign rdata_b = v_b ? q_b : '0;

endmodule

### rtl/core/rfpa_iter_unit.sv
// Shared iterative multiply/divide unit built around one 34-bit adder.
// Signed shift-add multiply or restoring divide, one bit per cycle.
// Depends on rfpa_pkg.
module rfpa_iter_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  rfpa_pkg::iter_req_t         req,
  input  logic [rfpa_pkg::WORD_W-1:0] opnd_x,
  input  logic [rfpa_pkg::WORD_W-1:0] init_hi,
  input  logic [rfpa_pkg::WORD_W-1:0] init_lo,
  output rfpa_pkg::iter_res_t         res
);
  import rfpa_pkg::*;

  localparam int CNT_W = $clog2(WORD_W);

  logic              busy;
  logic              done;
  logic              is_div;
  logic [CNT_W-1:0]  cnt;
  logic [WORD_W:0]   hi;
  logic [WORD_W-1:0] lo;
  logic [WORD_W-1:0] x;
  logic              last;
  logic [WORD_W:0]   t;
  logic [WORD_W+1:0] add_a;
  logic [WORD_W+1:0] add_b;
  logic              cin;
  logic [WORD_W+1:0] sum;
  logic              nonneg;

  assign last = (cnt == CNT_W'(WORD_W - 1));

  // Operand selection for the shared adder.
  always_comb begin
    t = {hi[WORD_W-1:0], lo[WORD_W-1]};
    if (is_div) begin
      add_a = {1'b0, t};
      add_b = ~{2'b00, x};
      cin   = 1'b1;
    end else begin
      add_a = {hi[WORD_W], hi};
      if (lo[0]) begin
        // The top multiplier bit has negative weight, so it subtracts.
        add_b = last ? ~{{2{x[WORD_W-1]}}, x} : {{2{x[WORD_W-1]}}, x};
        cin   = last;
      end else begin
        add_b = '0;
        cin   = 1'b0;
      end
    end
    sum    = add_a + add_b + {{(WORD_W+1){1'b0}}, cin};
    nonneg = ~sum[WORD_W+1];
  end

  // Control of the iteration count.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial remainder or product registers.
  always_ff @(posedge clk) begin
    if (req.start) begin
      hi     <= {1'b0, init_hi};
      lo     <= init_lo;
      x      <= opnd_x;
      is_div <= req.is_div;
    end else if (busy) begin
      if (is_div) begin
        hi <= nonneg ? sum[WORD_W:0] : t;
        lo <= {lo[WORD_W-2:0], nonneg};
      end else begin
        hi <= {sum[WORD_W], sum[WORD_W:1]};
        lo <= {sum[0], lo[WORD_W-1:1]};
      end
    end
  end

  assign res.done = done;
  assign res.hi   = hi[WORD_W-1:0];
  assign res.lo   = lo;

endmodule

### rtl/core/rr_fixed_point_alu.sv
// Top level of the register-to-register fixed-point unit: sequencer, combinational
// logic for the short instructions, output register. Uses rfpa_pkg, rfpa_regfile
// and rfpa_iter_unit.
//
//  Channel  Direction  Handshake          Payload
//  s_*      in         s_tvalid/s_tready  s_tuser kind, s_tdata instruction or write
//  m_*      out        m_tvalid/m_tready  m_tdata condition code, exception, registers
//  cfg_*    in         cfg_wen            cfg_wdata overflow mask
//
// A register write passes WB1, WB2, RDO and OUT; a short instruction passes RD1, RD2 and
// EXEC first, and MR and DR then add PREP, ITER and FIX (an odd pair goes from EXEC and an
// early divide fault from PREP straight to RDO): the shared unit steps one bit a cycle. The
// input is ready again from the edge that offers the result. Reset is synchronous and
// clears the registers, the condition code and the mask. A stalled result holds in the
// output register; the next word is accepted and waits before output.
module rr_fixed_point_alu (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic        s_tuser,   // [0] kind
  // [3:0] opcode, [7:4] first_reg, [11:8] second_reg, [43:12] value, rest zero
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [1:0] cond_code, [3:2] exception, [35:4] first_value, [67:36] pair_value
  output logic [71:0] m_tdata,
  input  logic        cfg_wen,
  input  logic        cfg_wdata
);
  import rfpa_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_RD1  = 11'b000_0000_0010,
    S_RD2  = 11'b000_0000_0100,
    S_EXEC = 11'b000_0000_1000,
    S_PREP = 11'b000_0001_0000,
    S_ITER = 11'b000_0010_0000,
    S_FIX  = 11'b000_0100_0000,
    S_WB1  = 11'b000_1000_0000,
    S_WB2  = 11'b001_0000_0000,
    S_RDO  = 11'b010_0000_0000,
    S_OUT  = 11'b100_0000_0000
  } state_t;

  state_t              state;
  state_t              state_next;
  logic                omask;
  logic [1:0]          cc;
  logic [1:0]          exc;
  logic [3:0]          op;
  logic [REG_AW-1:0]   r1;
  logic [REG_AW-1:0]   r2;
  logic [REG_AW-1:0]   r1p;
  logic [WORD_W-1:0]   a;
  logic [WORD_W-1:0]   b;
  logic                w1_en;
  logic                w2_en;
  logic [WORD_W-1:0]   w1_data;
  logic [WORD_W-1:0]   w2_data;
  logic [WORD_W-1:0]   opx;
  logic [WORD_W-1:0]   ophi;
  logic [WORD_W-1:0]   oplo;
  logic                accept;

  logic                rf_we;
  logic [REG_AW-1:0]   rf_waddr;
  logic [WORD_W-1:0]   rf_wdata;
  logic [REG_AW-1:0]   rf_raddr_a;
  logic [REG_AW-1:0]   rf_raddr_b;
  logic [WORD_W-1:0]   rf_rdata_a;
  logic [WORD_W-1:0]   rf_rdata_b;

  iter_req_t           iter_req;
  iter_res_t           iter_res;

  // Short-instruction results.
  logic [WORD_W-1:0]   neg_b;
  logic [WORD_W:0]     sum_ab;
  logic [WORD_W:0]     dif_ab;
  logic [WORD_W-1:0]   ex_res;
  logic                ex_wr;
  logic [1:0]          ex_cc;
  logic                ex_ovf;
  logic                ex_long;
  logic [2*WORD_W-1:0] dvd;
  logic [2*WORD_W-1:0] mag;
  logic [WORD_W-1:0]   dmag;
  logic                div_fault;
  logic                qneg;
  logic                q_fits;

  function automatic logic [1:0] cc_of_sign(input logic [WORD_W-1:0] v);
    if (v == '0) begin
      return CC_ZERO;
    end
    return v[WORD_W-1] ? CC_LOW : CC_HIGH;
  endfunction

  assign accept   = s_tvalid & s_tready;
  assign s_tready = (state == S_IDLE);
  assign r1p      = r1 + 1'b1;

  rfpa_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .we      (rf_we),
    .waddr   (rf_waddr),
    .wdata   (rf_wdata),
    .raddr_a (rf_raddr_a),
    .raddr_b (rf_raddr_b),
    .rdata_a (rf_rdata_a),
    .rdata_b (rf_rdata_b)
  );

  rfpa_iter_unit u_iter (
    .clk     (clk),
    .rst     (rst),
    .req     (iter_req),
    .opnd_x  (opx),
    .init_hi (ophi),
    .init_lo (oplo),
    .res     (iter_res)
  );

  // Register file addressing by sequencer step.
  always_comb begin
    rf_raddr_a = (state == S_RD2) ? r1p : r1;
    rf_raddr_b = (state == S_RD1) ? r2 : r1p;
    rf_we      = ((state == S_WB1) && w1_en) || ((state == S_WB2) && w2_en);
    rf_waddr   = (state == S_WB1) ? r1 : r1p;
    rf_wdata   = (state == S_WB1) ? w1_data : w2_data;
  end

  // Combinational datapath for the short instructions.
  always_comb begin
    neg_b   = '0 - b;
    sum_ab  = {1'b0, a} + {1'b0, b};
    dif_ab  = {1'b0, a} + {1'b0, ~b} + {{WORD_W{1'b0}}, 1'b1};
    ex_res  = b;
    ex_wr   = 1'b0;
    ex_cc   = cc;
    ex_ovf  = 1'b0;
    ex_long = 1'b0;
    case (op)
      OP_LPR: begin
        ex_res = b[WORD_W-1] ? neg_b : b;
        ex_wr  = 1'b1;
        ex_ovf = (b == SIGN32);
        ex_cc  = ex_ovf ? CC_OVF : ((ex_res != '0) ? CC_HIGH : CC_ZERO);
      end
      OP_LNR: begin
        ex_res = b[WORD_W-1] ? b : neg_b;
        ex_wr  = 1'b1;
        ex_cc  = (ex_res != '0) ? CC_LOW : CC_ZERO;
      end
      OP_LTR: begin
        ex_res = b;
        ex_wr  = 1'b1;
        ex_cc  = cc_of_sign(b);
      end
      OP_LCR: begin
        ex_res = neg_b;
        ex_wr  = 1'b1;
        ex_ovf = (b == SIGN32);
        ex_cc  = ex_ovf ? CC_OVF : cc_of_sign(neg_b);
      end
      OP_NR, OP_OR, OP_XR: begin
        if (op == OP_NR) begin
          ex_res = a & b;
        end else if (op == OP_OR) begin
          ex_res = a | b;
        end else begin
          ex_res = a ^ b;
        end
        ex_wr = 1'b1;
        ex_cc = (ex_res != '0) ? CC_LOW : CC_ZERO;
      end
      OP_CLR: begin
        ex_cc = (a == b) ? CC_ZERO : ((a < b) ? CC_LOW : CC_HIGH);
      end
      OP_LR: begin
        ex_res = b;
        ex_wr  = 1'b1;
      end
      OP_CR: begin
        ex_cc = (a == b) ? CC_ZERO : (($signed(a) < $signed(b)) ? CC_LOW : CC_HIGH);
      end
      OP_AR: begin
        ex_res = sum_ab[WORD_W-1:0];
        ex_wr  = 1'b1;
        ex_ovf = ((a[WORD_W-1] ^ ex_res[WORD_W-1]) & (b[WORD_W-1] ^ ex_res[WORD_W-1]));
        ex_cc  = ex_ovf ? CC_OVF : cc_of_sign(ex_res);
      end
      OP_SR: begin
        ex_res = dif_ab[WORD_W-1:0];
        ex_wr  = 1'b1;
        ex_ovf = ((a[WORD_W-1] ^ b[WORD_W-1]) & (a[WORD_W-1] ^ ex_res[WORD_W-1]));
        ex_cc  = ex_ovf ? CC_OVF : cc_of_sign(ex_res);
      end
      OP_MR, OP_DR: begin
        ex_long = 1'b1;
      end
      OP_ALR: begin
        ex_res = sum_ab[WORD_W-1:0];
        ex_wr  = 1'b1;
        ex_cc  = {sum_ab[WORD_W], ex_res != '0};
      end
      default: begin
        // SLR: the carry is the carry out of a + ~b + 1.
        ex_res = dif_ab[WORD_W-1:0];
        ex_wr  = 1'b1;
        ex_cc  = {dif_ab[WORD_W], ex_res != '0};
      end
    endcase
  end

  // Divide operand preparation and fault checks.
  always_comb begin
    dvd       = {a, rf_rdata_a};
    mag       = a[WORD_W-1] ? ('0 - dvd) : dvd;
    dmag      = b[WORD_W-1] ? neg_b : b;
    div_fault = (opx == '0) || (ophi >= opx);
    qneg      = a[WORD_W-1] ^ b[WORD_W-1];
    q_fits    = qneg ? (iter_res.lo <= SIGN32) : ~iter_res.lo[WORD_W-1];
  end

  // Sequencer next state.
  always_comb begin
    state_next     = state;
    iter_req.start = 1'b0;
    iter_req.is_div = (op == OP_DR);
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (s_tuser == KIND_WRITE) ? S_WB1 : S_RD1;
        end
      end
      S_RD1: state_next = S_RD2;
      S_RD2: state_next = S_EXEC;
      S_EXEC: begin
        if (!ex_long) begin
          state_next = S_WB1;
        end else if (r1[0]) begin
          state_next = S_RDO;
        end else begin
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        if ((op == OP_DR) && div_fault) begin
          state_next = S_RDO;
        end else begin
          iter_req.start = 1'b1;
          state_next     = S_ITER;
        end
      end
      S_ITER: begin
        if (iter_res.done) begin
          state_next = S_FIX;
        end
      end
      S_FIX: state_next = S_WB1;
      S_WB1: state_next = S_WB2;
      S_WB2: state_next = S_RDO;
      S_RDO: state_next = S_OUT;
      S_OUT: begin
        if (!m_tvalid || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      omask    <= 1'b0;
      cc       <= CC_ZERO;
      w1_en    <= 1'b0;
      w2_en    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        omask <= cfg_wdata;
      end
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            w1_en <= (s_tuser == KIND_WRITE);
            w2_en <= 1'b0;
          end
        end
        S_EXEC: begin
          w1_en <= ex_wr;
          cc    <= ex_cc;
        end
        S_FIX: begin
          if (op == OP_MR) begin
            w1_en <= 1'b1;
            w2_en <= 1'b1;
          end else begin
            w1_en <= q_fits;
            w2_en <= q_fits;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          op      <= s_tdata[3:0];
          r1      <= s_tdata[7:4];
          r2      <= s_tdata[11:8];
          w1_data <= s_tdata[43:12];
          exc     <= EXC_NONE;
        end
      end
      S_RD2: begin
        a <= rf_rdata_a;
        b <= rf_rdata_b;
      end
      S_EXEC: begin
        w1_data <= ex_res;
        if (ex_long && r1[0]) begin
          exc <= EXC_SPEC;
        end else if (ex_ovf && omask) begin
          exc <= EXC_OVF;
        end
        // MR multiplies R1+1 by R2; DR divides the pair by the magnitude of R2.
        if (op == OP_MR) begin
          opx  <= b;
          ophi <= '0;
          oplo <= rf_rdata_a;
        end else begin
          opx  <= dmag;
          ophi <= mag[2*WORD_W-1:WORD_W];
          oplo <= mag[WORD_W-1:0];
        end
      end
      S_PREP: begin
        if ((op == OP_DR) && div_fault) begin
          exc <= EXC_DIV;
        end
      end
      S_FIX: begin
        if (op == OP_MR) begin
          w1_data <= iter_res.hi;
          w2_data <= iter_res.lo;
        end else begin
          // Quotient takes the algebraic sign, remainder that of the dividend.
          w2_data <= qneg ? ('0 - iter_res.lo) : iter_res.lo;
          w1_data <= a[WORD_W-1] ? ('0 - iter_res.hi) : iter_res.hi;
          if (!q_fits) begin
            exc <= EXC_DIV;
          end
        end
      end
      S_OUT: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= {4'b0000, rf_rdata_b, rf_rdata_a, exc, cc};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/core/rfpa_checker.sv
// Port-level checker for the fixed-point unit, bound to the top level.
// Watches the stream ports only. Depends on nothing else.
module rfpa_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata
);

  // No result word is offered straight after reset.
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A stalled result word holds its value.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result word changed");

  // The unit is busy once a word is taken, so the input is not ready again straight away.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready straight after acceptance");

  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> ##3 !s_tready)
    else $error("input ready too early after acceptance");

  // Padding bits of the result word stay zero.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[71:68] == 4'b0000))
    else $error("result padding not zero");

endmodule

bind rr_fixed_point_alu rfpa_checker u_rfpa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### sim/tb_rr_fixed_point_alu.sv
`timescale 1ns / 100ps
// Self-checking testbench for rr_fixed_point_alu: a directed stimulus table followed by
// random instruction and register-write words, checked against a behavioural predictor.
// Depends on rfpa_pkg and the RTL of rr_fixed_point_alu.
module tb_rr_fixed_point_alu;
  import rfpa_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned PHASE_WORDS = 312;
  localparam int unsigned LONG_HOLD_AT = 400;
  localparam int unsigned LONG_HOLD_CYCLES = 400;

  // Instruction word as it sits in s_tdata, opcode in the lowest bits.
  typedef struct packed {
    logic [31:0] value;
    logic [3:0]  second_reg;
    logic [3:0]  first_reg;
    logic [3:0]  opcode;
  } instr_word_t;

  // Result word as it sits in m_tdata, condition code in the lowest bits.
  typedef struct packed {
    logic [31:0] pair_value;
    logic [31:0] first_value;
    logic [1:0]  exception;
    logic [1:0]  cond_code;
  } outcome_t;

  // One row of the directed table; res is only used when known is set.
  typedef struct packed {
    logic        kind;
    instr_word_t word;
    bit          known;
    outcome_t    res;
  } row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic        s_tuser;   // [0] kind
  // [3:0] opcode, [7:4] first_reg, [11:8] second_reg, [43:12] value, rest zero
  logic [47:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  // [1:0] cond_code, [3:2] exception, [35:4] first_value, [67:36] pair_value
  logic [71:0] m_tdata;
  logic        cfg_wen;
  logic        cfg_wdata;

  // Shadow of the unit's architectural state.
  logic [31:0] gpr [NUM_REGISTERS];
  logic [1:0]  psw_cc;
  logic        ovf_mask_shadow;

  outcome_t    pending_results [$];
  outcome_t    seen_result;
  outcome_t    oldest_result;
  row_t        directed_rows [26];
  int unsigned error_count;
  int unsigned words_sent;
  int unsigned results_checked;
  int unsigned exc_tally [4];
  int unsigned cycle_count;
  bit          no_idle;

  rr_fixed_point_alu u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  // Free-running clock.
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Executes one word on the shadow state and returns the result the unit should give.
  function automatic outcome_t execute_instr(input logic kind, input instr_word_t w);
    logic [3:0]  r1, r1p;
    logic [31:0] a, b, s;
    logic [1:0]  exc;
    logic        ovf;
    logic [63:0] prod, dvd, mag, dmag, quo, rem;
    logic        dneg, vneg, qneg, fits;
    logic [32:0] diff;
    outcome_t    o;
    r1 = w.first_reg;
    r1p = r1 + 4'd1;
    a = gpr[r1];
    b = gpr[w.second_reg];
    exc = EXC_NONE;
    ovf = 1'b0;
    if (kind == KIND_WRITE) begin
      gpr[r1] = w.value;
    end else begin
      case (w.opcode)
        OP_LPR: begin
          s = b[31] ? 32'd0 - b : b;
          gpr[r1] = s;
          if (b == SIGN32) begin
            psw_cc = CC_OVF;
            ovf = 1'b1;
          end else psw_cc = (s != 0) ? CC_HIGH : CC_ZERO;
        end
        OP_LNR: begin
          s = b[31] ? b : 32'd0 - b;
          gpr[r1] = s;
          psw_cc = (s != 0) ? CC_LOW : CC_ZERO;
        end
        OP_LTR: begin
          gpr[r1] = b;
          psw_cc = (b == 0) ? CC_ZERO : (b[31] ? CC_LOW : CC_HIGH);
        end
        OP_LCR: begin
          s = 32'd0 - b;
          gpr[r1] = s;
          if (b == SIGN32) begin
            psw_cc = CC_OVF;
            ovf = 1'b1;
          end else psw_cc = (s == 0) ? CC_ZERO : (s[31] ? CC_LOW : CC_HIGH);
        end
        OP_NR, OP_OR, OP_XR: begin
          s = (w.opcode == OP_NR) ? (a & b) : (w.opcode == OP_OR) ? (a | b) : (a ^ b);
          gpr[r1] = s;
          psw_cc = (s != 0) ? CC_LOW : CC_ZERO;
        end
        OP_CLR: psw_cc = (a == b) ? CC_ZERO : ((a < b) ? CC_LOW : CC_HIGH);
        OP_LR: gpr[r1] = b;
        OP_CR: psw_cc = (a == b) ? CC_ZERO : (($signed(a) < $signed(b)) ? CC_LOW : CC_HIGH);
        OP_AR, OP_SR: begin
          s = (w.opcode == OP_AR) ? a + b : a - b;
          gpr[r1] = s;
          if (w.opcode == OP_AR) ovf = (a[31] ^ s[31]) & (b[31] ^ s[31]);
          else ovf = (a[31] ^ b[31]) & (a[31] ^ s[31]);
          if (ovf) psw_cc = CC_OVF;
          else psw_cc = (s == 0) ? CC_ZERO : (s[31] ? CC_LOW : CC_HIGH);
        end
        OP_MR: begin
          if (r1[0]) exc = EXC_SPEC;
          else begin
            prod = {{32{gpr[r1p][31]}}, gpr[r1p]} * {{32{b[31]}}, b};
            gpr[r1] = prod[63:32];
            gpr[r1p] = prod[31:0];
          end
        end
        OP_DR: begin
          // Sign and magnitude division: quotient takes the algebraic sign,
          // remainder the sign of the dividend.
          if (r1[0]) exc = EXC_SPEC;
          else begin
            dvd = {a, gpr[r1p]};
            dneg = a[31];
            vneg = b[31];
            mag = dneg ? 64'd0 - dvd : dvd;
            dmag = {32'd0, vneg ? 32'd0 - b : b};
            if (dmag == 0) exc = EXC_DIV;
            else begin
              quo = mag / dmag;
              rem = mag % dmag;
              qneg = dneg ^ vneg;
              fits = qneg ? (quo <= 64'h8000_0000) : (quo <= 64'h7FFF_FFFF);
              if (!fits) exc = EXC_DIV;
              else begin
                gpr[r1p] = qneg ? 32'd0 - quo[31:0] : quo[31:0];
                gpr[r1] = dneg ? 32'd0 - rem[31:0] : rem[31:0];
              end
            end
          end
        end
        OP_ALR: begin
          s = a + b;
          gpr[r1] = s;
          psw_cc = {s < a, s != 0};
        end
        OP_SLR: begin
          // Logical subtract as a + ~b + 1; the carry out is the borrow-free flag.
          diff = {1'b0, a} + {1'b0, ~b} + 33'd1;
          s = diff[31:0];
          gpr[r1] = s;
          psw_cc = {diff[32], s != 0};
        end
      endcase
      if (ovf && ovf_mask_shadow) exc = EXC_OVF;
    end
    o.cond_code = psw_cc;
    o.exception = exc;
    o.first_value = gpr[r1];
    o.pair_value = gpr[r1p];
    return o;
  endfunction

  // Idle lengths: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Operand values weighted towards the edges of the signed and unsigned ranges.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return SIGN32;
      2: return 32'h7FFF_FFFF;
      3: return 32'hFFFF_FFFF;
      4, 5: return 32'($urandom_range(1, 255));
      6: return 32'd0 - 32'($urandom_range(1, 255));
      default: return $urandom;
    endcase
  endfunction

  function automatic row_t row(input logic kind, input logic [3:0] op, input logic [3:0] r1,
                               input logic [3:0] r2, input logic [31:0] value,
                               input bit known = 1'b0, input logic [1:0] cc = CC_ZERO,
                               input logic [1:0] exc = EXC_NONE,
                               input logic [31:0] fv = 32'd0, input logic [31:0] pv = 32'd0);
    row_t r;
    r.kind = kind;
    r.word = '{value: value, second_reg: r2, first_reg: r1, opcode: op};
    r.known = known;
    r.res = '{pair_value: pv, first_value: fv, exception: exc, cond_code: cc};
    return r;
  endfunction

  // Offers one word, waits for it to be taken and records the result it must cause.
  task automatic send_item(input logic kind, input instr_word_t w, input bit known,
                           input outcome_t given);
    int unsigned gap;
    outcome_t predicted;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {4'b0000, w};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = execute_instr(kind, w);
    pending_results.push_back(known ? given : predicted);
    words_sent++;
  endtask

  task automatic send_write(input logic [3:0] r1, input logic [31:0] value);
    send_item(KIND_WRITE, '{value: value, second_reg: 4'($urandom),
              first_reg: r1, opcode: 4'($urandom)}, 1'b0, '0);
  endtask

  task automatic send_exec(input logic [3:0] op, input logic [3:0] r1, input logic [3:0] r2);
    send_item(KIND_EXEC, '{value: $urandom, second_reg: r2, first_reg: r1, opcode: op},
              1'b0, '0);
  endtask

  // Lets every outstanding result drain so that the unit is idle.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_overflow_mask(input logic v);
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    ovf_mask_shadow = v;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Result checker: every word taken on the master side is compared with the oldest
  // outstanding expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_result = m_tdata[67:0];
      if (pending_results.size() == 0) begin
        $display("%0t ns: result word with nothing outstanding, expected none, got %h",
                 $time, seen_result);
        error_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        exc_tally[oldest_result.exception]++;
        results_checked++;
        check_field("cond_code", oldest_result.cond_code, seen_result.cond_code);
        check_field("exception", oldest_result.exception, seen_result.exception);
        check_field("first_value", oldest_result.first_value, seen_result.first_value);
        check_field("pair_value", oldest_result.pair_value, seen_result.pair_value);
      end
    end
  end

  // Result side: random back-pressure, and one long hold-off so that the unit fills up.
  initial begin : result_drain
    int unsigned taken;
    int unsigned stall;
    bit held;
    taken = 0;
    stall = 0;
    held = 1'b0;
    m_tready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        taken++;
        stall = no_idle ? 0 : pick_gap();
        if (!held && taken == LONG_HOLD_AT) begin
          stall = LONG_HOLD_CYCLES;
          held = 1'b1;
        end
      end else if (stall == 0 && !no_idle && $urandom_range(0, 31) == 0) begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else m_tready <= 1'b1;
    end
  end

  // Watchdog on the total run length.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped after %0d cycles with %0d results outstanding",
             cycle_count, pending_results.size());
    $display("FAILED: results differ");
    $finish;
  end

  // Stimulus: reset, directed table, then random phases under alternating mask settings.
  initial begin : stimulus
    int unsigned phase_words;
    int unsigned sel;
    logic [3:0]  op, r1, r2;
    logic [31:0] lo, hi, divisor;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = 1'b0;
    s_tdata = '0;
    cfg_wen = 1'b0;
    cfg_wdata = 1'b0;
    no_idle = 1'b0;
    error_count = 0;
    words_sent = 0;
    results_checked = 0;
    foreach (exc_tally[i]) exc_tally[i] = 0;
    foreach (gpr[i]) gpr[i] = 32'd0;
    psw_cc = CC_ZERO;
    ovf_mask_shadow = 1'b0;

    directed_rows = '{
      // Straight after reset every register and the code read as zero.
      row(KIND_EXEC, OP_LTR, 4'd0, 4'd1, 32'd0, 1, CC_ZERO, EXC_NONE, 32'd0, 32'd0),
      row(KIND_WRITE, OP_LPR, 4'd1, 4'd0, SIGN32, 1, CC_ZERO, EXC_NONE, SIGN32, 32'd0),
      row(KIND_WRITE, OP_LPR, 4'd2, 4'd0, 32'h7FFF_FFFF, 1, CC_ZERO, EXC_NONE,
          32'h7FFF_FFFF, 32'd0),
      row(KIND_WRITE, OP_LPR, 4'd3, 4'd0, 32'hFFFF_FFFF, 1, CC_ZERO, EXC_NONE,
          32'hFFFF_FFFF, 32'd0),
      // Positive and complement of the most negative number overflow.
      row(KIND_EXEC, OP_LPR, 4'd4, 4'd1, 32'd0, 1, CC_OVF, EXC_OVF, SIGN32, 32'd0),
      row(KIND_EXEC, OP_LCR, 4'd5, 4'd1, 32'd0, 1, CC_OVF, EXC_OVF, SIGN32, 32'd0),
      row(KIND_EXEC, OP_LR, 4'd6, 4'd2, 32'd0),
      // Signed add and subtract overflow.
      row(KIND_EXEC, OP_AR, 4'd6, 4'd2, 32'd0, 1, CC_OVF, EXC_OVF, 32'hFFFF_FFFE, 32'd0),
      row(KIND_EXEC, OP_SR, 4'd4, 4'd2, 32'd0, 1, CC_OVF, EXC_OVF, 32'd1, SIGN32),
      // Odd first register of a pair, zero divisor and a quotient that does not fit.
      row(KIND_EXEC, OP_MR, 4'd3, 4'd2, 32'd0, 1, CC_OVF, EXC_SPEC, 32'hFFFF_FFFF, 32'd1),
      row(KIND_EXEC, OP_DR, 4'd9, 4'd2, 32'd0, 1, CC_OVF, EXC_SPEC, 32'd0, 32'd0),
      row(KIND_EXEC, OP_DR, 4'd8, 4'd10, 32'd0, 1, CC_OVF, EXC_DIV, 32'd0, 32'd0),
      row(KIND_EXEC, OP_DR, 4'd4, 4'd3, 32'd0, 1, CC_OVF, EXC_DIV, 32'd1, SIGN32),
      row(KIND_EXEC, OP_MR, 4'd4, 4'd2, 32'd0),
      // Negative dividend over a positive divisor: both results come out negative.
      row(KIND_WRITE, OP_LPR, 4'd12, 4'd0, 32'hFFFF_FFFF),
      row(KIND_WRITE, OP_LPR, 4'd13, 4'd0, 32'hFFFF_FFF9),
      row(KIND_WRITE, OP_LPR, 4'd14, 4'd0, 32'd2),
      row(KIND_EXEC, OP_DR, 4'd12, 4'd14, 32'd0),
      // The pair register wraps from 15 to 0.
      row(KIND_EXEC, OP_LNR, 4'd15, 4'd2, 32'd0),
      row(KIND_EXEC, OP_NR, 4'd3, 4'd3, 32'd0),
      // Logical and arithmetic compare disagree on the same operands.
      row(KIND_EXEC, OP_CLR, 4'd1, 4'd2, 32'd0),
      row(KIND_EXEC, OP_CR, 4'd1, 4'd2, 32'd0),
      row(KIND_EXEC, OP_OR, 4'd7, 4'd1, 32'd0),
      row(KIND_EXEC, OP_XR, 4'd3, 4'd3, 32'd0),
      // Logical add and subtract with carry out.
      row(KIND_EXEC, OP_ALR, 4'd1, 4'd1, 32'd0),
      row(KIND_EXEC, OP_SLR, 4'd0, 4'd0, 32'd0)
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_overflow_mask(1'b1);
    foreach (directed_rows[i])
      send_item(directed_rows[i].kind, directed_rows[i].word, directed_rows[i].known,
                directed_rows[i].res);
    wait_idle();

    // Random phases; the third runs with no idling on either side.
    for (int phase = 0; phase < 4; phase++) begin
      set_overflow_mask(phase[0]);
      no_idle = (phase == 2);
      phase_words = 0;
      while (phase_words < PHASE_WORDS) begin
        sel = $urandom_range(0, 99);
        op = 4'($urandom_range(0, 15));
        r1 = 4'($urandom_range(0, 15));
        r2 = 4'($urandom_range(0, 15));
        if (sel < 20) begin
          send_write(r1, pick_value());
          phase_words += 1;
        end else if (sel < 50) begin
          send_exec(op, r1, r2);
          phase_words += 1;
        end else begin
          // Prepared sequence: load the operands, then run the instruction on them.
          if ((op == OP_MR || op == OP_DR) && $urandom_range(0, 9) != 0) r1[0] = 1'b0;
          if (op == OP_DR) begin
            lo = pick_value();
            divisor = ($urandom_range(0, 19) == 0) ? 32'd0 : pick_value();
            case ($urandom_range(0, 9))
              0, 1: hi = $urandom;
              2, 3: hi = {32{lo[31]}} + 32'($urandom_range(0, 2)) - 32'd1;
              default: hi = {32{lo[31]}};
            endcase
            send_write(r2, divisor);
            send_write(r1 + 4'd1, lo);
            send_write(r1, hi);
            phase_words += 3;
          end else begin
            send_write(r2, pick_value());
            send_write((op == OP_MR) ? r1 + 4'd1 : r1, pick_value());
            phase_words += 2;
          end
          send_exec(op, r1, r2);
          phase_words += 1;
        end
      end
      wait_idle();
    end

    repeat (60) @(posedge clk);
    $display("Run covered %0d words (%0d directed) and %0d checked results under both",
             words_sent, $size(directed_rows), results_checked);
    $display("overflow mask settings; exceptions: %0d specification, %0d overflow, %0d divide",
             exc_tally[EXC_SPEC], exc_tally[EXC_OVF], exc_tally[EXC_DIV]);
    if (error_count == 0 && pending_results.size() == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule

### sim.f
rtl/core/rfpa_pkg.sv
rtl/core/rfpa_regfile.sv
rtl/core/rfpa_iter_unit.sv
rtl/core/rr_fixed_point_alu.sv
rtl/core/rfpa_checker.sv
sim/tb_rr_fixed_point_alu.sv
